FILE: design/rts_cts_link_controller_macros.svh
// Assertion macros shared by the link controller files.
`ifndef RTS_CTS_LINK_CONTROLLER_MACROS_SVH
`define RTS_CTS_LINK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define RCL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link controller check failed");

// next-cycle implication
`define RCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link controller check failed");

`endif

FILE: design/rcl_pkg.sv
package rcl_pkg;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_FRAME = 2'd2,
      KIND_SEND  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_UNSYNC      = 3'd0,
      ST_IDLE        = 3'd1,
      ST_WAIT_CTS    = 3'd2,
      ST_WAIT_ACK    = 3'd3,
      ST_WAIT_DATA   = 3'd4,
      ST_WAIT_PACKET = 3'd5
   } link_state_type;

   localparam logic [3:0] FRAME_RTS  = 4'd0;
   localparam logic [3:0] FRAME_CTS  = 4'd1;
   localparam logic [3:0] FRAME_ACK  = 4'd2;
   localparam logic [3:0] FRAME_DATA = 4'd3;

   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_RTS         = 3'd1;
   localparam logic [2:0] ACT_CTS         = 3'd2;
   localparam logic [2:0] ACT_SEND_PACKET = 3'd3;
   localparam logic [2:0] ACT_ACK         = 3'd4;

   localparam logic [3:0] BROADCAST_NODE = 4'd15;
   localparam logic [7:0] HEADER_BYTES   = 8'd4;

   localparam logic CSR_NODE_ID   = 1'b0;
   localparam logic CSR_IS_MASTER = 1'b1;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] slot_pick;
      logic       clear_first;
      logic       clear_second;
      logic [3:0] frame_dest;
      logic [3:0] frame_src;
      logic [3:0] frame_type;
      logic [3:0] frame_receiver;
      logic [3:0] req_receiver;
      logic [3:0] req_handle;
      logic [7:0] req_length;
      logic       alloc_ok;
   } item_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] to_node;
      logic [1:0] rts_slot;
      logic [3:0] packet_handle;
      logic [7:0] packet_size;
      logic       accepted;
      logic       head_done;
      logic       deliver_local;
      logic       forward;
      logic       timer_resync;
      logic [2:0] state_now;
   } result_type;

   typedef struct packed {
      logic [7:0] size;
      logic [3:0] receiver;
      logic [3:0] handle;
   } qentry_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      qentry_type entry;
   } qctl_type;

   typedef struct packed {
      qentry_type head;
      logic       nonempty;
      logic       full;
   } qstat_type;

endpackage

FILE: design/rts_cts_link_controller.sv
// RTS/CTS/DATA/ACK link controller for a slotted radio MAC. Every item (start, slot
// tick, received frame or send request) yields exactly one result item carrying the
// frame to transmit, queue events and the link state after the item. Items pass an
// input register, combinational state-update logic and a result register: a new
// item is taken every cycle unless the result side stalls. The packet queue is a
// RAM of QUEUE_DEPTH descriptors with a registered read; the head is prefetched
// every cycle so it is ready for the next item. The user must write node_id and
// is_master through the csr port only while idle; the block does not enforce it.
`include "rts_cts_link_controller_macros.svh"

module rts_cts_link_controller #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_slot_pick,
   input  logic       req_clear_first,
   input  logic       req_clear_second,
   input  logic [3:0] req_frame_dest,
   input  logic [3:0] req_frame_src,
   input  logic [3:0] req_frame_type,
   input  logic [3:0] req_frame_receiver,
   input  logic [3:0] req_req_receiver,
   input  logic [3:0] req_req_handle,
   input  logic [7:0] req_req_length,
   input  logic       req_alloc_ok,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_action,
   output logic [3:0] rsp_to_node,
   output logic [1:0] rsp_rts_slot,
   output logic [3:0] rsp_packet_handle,
   output logic [7:0] rsp_packet_size,
   output logic       rsp_accepted,
   output logic       rsp_head_done,
   output logic       rsp_deliver_local,
   output logic       rsp_forward,
   output logic       rsp_timer_resync,
   output logic [2:0] rsp_state_now,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [3:0] csr_data
);

   logic                s1_valid_ff, s1_valid_in;
   rcl_pkg::item_type   s1_item_ff, s1_item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rcl_pkg::result_type rsp_data_ff, rsp_data_in;
   logic [3:0]          node_id_ff, node_id_in;
   logic                is_master_ff, is_master_in;
   rcl_pkg::item_type   req_item;
   rcl_pkg::result_type link_result;
   rcl_pkg::qctl_type   qctl;
   rcl_pkg::qstat_type  qstat;
   logic                advance;
   logic                take;

   assign csr_ready = 1'b1;

   always_comb begin
      node_id_in   = node_id_ff;
      is_master_in = is_master_ff;
      if (csr_valid) begin
         case (csr_index)
            rcl_pkg::CSR_NODE_ID:   node_id_in   = csr_data;
            rcl_pkg::CSR_IS_MASTER: is_master_in = csr_data[0];
            default:                node_id_in   = node_id_ff;
         endcase
      end
   end

   assign req_item.kind           = rcl_pkg::kind_type'(req_kind);
   assign req_item.slot_pick      = req_slot_pick;
   assign req_item.clear_first    = req_clear_first;
   assign req_item.clear_second   = req_clear_second;
   assign req_item.frame_dest     = req_frame_dest;
   assign req_item.frame_src      = req_frame_src;
   assign req_item.frame_type     = req_frame_type;
   assign req_item.frame_receiver = req_frame_receiver;
   assign req_item.req_receiver   = req_req_receiver;
   assign req_item.req_handle     = req_req_handle;
   assign req_item.req_length     = req_req_length;
   assign req_item.alloc_ok       = req_alloc_ok;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign s1_item_in   = take ? req_item : s1_item_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = advance ? link_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         node_id_ff   <= '0;
         is_master_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         node_id_ff   <= node_id_in;
         is_master_ff <= is_master_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   rcl_link u_link (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (s1_item_ff),
      .node_id   (node_id_ff),
      .is_master (is_master_ff),
      .qstat     (qstat),
      .result    (link_result),
      .qctl      (qctl)
   );

   rcl_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .qctl  (qctl),
      .qstat (qstat)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_data_ff.action;
   assign rsp_to_node       = rsp_data_ff.to_node;
   assign rsp_rts_slot      = rsp_data_ff.rts_slot;
   assign rsp_packet_handle = rsp_data_ff.packet_handle;
   assign rsp_packet_size   = rsp_data_ff.packet_size;
   assign rsp_accepted      = rsp_data_ff.accepted;
   assign rsp_head_done     = rsp_data_ff.head_done;
   assign rsp_deliver_local = rsp_data_ff.deliver_local;
   assign rsp_forward       = rsp_data_ff.forward;
   assign rsp_timer_resync  = rsp_data_ff.timer_resync;
   assign rsp_state_now     = rsp_data_ff.state_now;

   `RCL_ASSERT_NEXT(a_item_reaches_result, clock, reset, s1_valid_ff && !rsp_stall, rsp_valid)

endmodule

FILE: design/rcl_ram.sv
module rcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a same-address write is seen on the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rcl_queue.sv
`include "rts_cts_link_controller_macros.svh"

module rcl_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  rcl_pkg::qctl_type  qctl,
   output rcl_pkg::qstat_type qstat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [PTR_W-1:0]    read_ff, read_in;
   logic [PTR_W-1:0]    write_ff, write_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                bypass_ff, bypass_in;
   rcl_pkg::qentry_type bypass_data_ff, bypass_data_in;
   logic [$bits(rcl_pkg::qentry_type)-1:0] ram_rd_data;

   always_comb begin
      read_in  = read_ff;
      write_in = write_ff;
      count_in = count_ff;
      if (qctl.clear) begin
         read_in  = '0;
         write_in = '0;
         count_in = '0;
      end else if (qctl.push) begin
         write_in = (write_ff == LAST_PTR) ? '0 : write_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (qctl.pop) begin
         read_in  = (read_ff == LAST_PTR) ? '0 : read_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   // write into the slot about to be read: forward it past the RAM
   assign bypass_in      = qctl.push && (write_ff == read_in);
   assign bypass_data_in = qctl.entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff   <= '0;
         write_ff  <= '0;
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         read_ff   <= read_in;
         write_ff  <= write_in;
         count_ff  <= count_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= bypass_data_in;
   end

   rcl_ram #(
      .WIDTH($bits(rcl_pkg::qentry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (qctl.push),
      .wr_addr (write_ff),
      .wr_data (qctl.entry),
      .rd_addr (read_in),
      .rd_data (ram_rd_data)
   );

   assign qstat.head     = bypass_ff ? bypass_data_ff : rcl_pkg::qentry_type'(ram_rd_data);
   assign qstat.nonempty = (count_ff != '0);
   assign qstat.full     = (count_ff == CNT_W'(QUEUE_DEPTH));

   `RCL_ASSERT_IMPLY(a_no_push_when_full, clock, reset, qctl.push, !qstat.full)
   `RCL_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, qctl.pop, qstat.nonempty)
   `RCL_ASSERT_NEXT(a_pop_decrements, clock, reset, qctl.pop && !qctl.clear && !qctl.push, count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: design/rcl_link.sv
`include "rts_cts_link_controller_macros.svh"

module rcl_link (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rcl_pkg::item_type   item,
   input  logic [3:0]          node_id,
   input  logic                is_master,
   input  rcl_pkg::qstat_type  qstat,
   output rcl_pkg::result_type result,
   output rcl_pkg::qctl_type   qctl
);

   rcl_pkg::link_state_type state_ff, state_in;
   logic [3:0]              partner_ff, partner_in;
   logic                    addressed;
   logic                    from_partner;
   logic                    ops_push, ops_pop, ops_clear;

   assign addressed    = (item.frame_dest == node_id) ||
                         (item.frame_dest == rcl_pkg::BROADCAST_NODE);
   assign from_partner = (partner_ff == item.frame_src);

   // next state
   always_comb begin
      state_in = state_ff;
      case (item.kind)
         rcl_pkg::KIND_START: begin
            state_in = is_master ? rcl_pkg::ST_IDLE : rcl_pkg::ST_UNSYNC;
         end
         rcl_pkg::KIND_TICK: begin
            if (state_ff != rcl_pkg::ST_UNSYNC) begin
               if (qstat.nonempty && item.clear_first && item.clear_second) begin
                  state_in = rcl_pkg::ST_WAIT_CTS;
               end else begin
                  state_in = rcl_pkg::ST_WAIT_PACKET;
               end
            end
         end
         rcl_pkg::KIND_FRAME: begin
            if (addressed) begin
               case (item.frame_type)
                  rcl_pkg::FRAME_RTS: begin
                     if (state_ff == rcl_pkg::ST_WAIT_PACKET ||
                         state_ff == rcl_pkg::ST_UNSYNC) begin
                        state_in = rcl_pkg::ST_WAIT_DATA;
                     end
                  end
                  rcl_pkg::FRAME_CTS: begin
                     if (state_ff == rcl_pkg::ST_WAIT_CTS && from_partner &&
                         qstat.nonempty) begin
                        state_in = rcl_pkg::ST_WAIT_ACK;
                     end else begin
                        state_in = rcl_pkg::ST_IDLE;
                     end
                  end
                  rcl_pkg::FRAME_ACK,
                  rcl_pkg::FRAME_DATA: begin
                     state_in = rcl_pkg::ST_IDLE;
                  end
                  default: begin
                     state_in = state_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // outputs, partner and queue operations
   always_comb begin
      result     = '0;
      partner_in = partner_ff;
      ops_push   = 1'b0;
      ops_pop    = 1'b0;
      ops_clear  = 1'b0;
      case (item.kind)
         rcl_pkg::KIND_START: begin
            ops_clear = 1'b1;
         end
         rcl_pkg::KIND_TICK: begin
            if (state_ff != rcl_pkg::ST_UNSYNC && qstat.nonempty && item.clear_first) begin
               partner_in = qstat.head.receiver;
               if (item.clear_second) begin
                  result.action   = rcl_pkg::ACT_RTS;
                  result.to_node  = qstat.head.receiver;
                  result.rts_slot = item.slot_pick;
               end
            end
         end
         rcl_pkg::KIND_FRAME: begin
            if (addressed) begin
               case (item.frame_type)
                  rcl_pkg::FRAME_RTS: begin
                     result.timer_resync = (state_ff == rcl_pkg::ST_UNSYNC);
                     if (state_ff == rcl_pkg::ST_WAIT_PACKET ||
                         state_ff == rcl_pkg::ST_UNSYNC) begin
                        result.action  = rcl_pkg::ACT_CTS;
                        result.to_node = item.frame_src;
                        partner_in     = item.frame_src;
                     end
                  end
                  rcl_pkg::FRAME_CTS: begin
                     if (state_ff == rcl_pkg::ST_WAIT_CTS && from_partner &&
                         qstat.nonempty) begin
                        result.action        = rcl_pkg::ACT_SEND_PACKET;
                        result.to_node       = partner_ff;
                        result.packet_handle = qstat.head.handle;
                        result.packet_size   = qstat.head.size;
                     end
                  end
                  rcl_pkg::FRAME_ACK: begin
                     if (state_ff == rcl_pkg::ST_WAIT_ACK && from_partner &&
                         qstat.nonempty) begin
                        result.packet_handle = qstat.head.handle;
                        result.head_done     = 1'b1;
                        ops_pop              = 1'b1;
                     end
                  end
                  rcl_pkg::FRAME_DATA: begin
                     if (state_ff == rcl_pkg::ST_WAIT_DATA && from_partner) begin
                        result.action        = rcl_pkg::ACT_ACK;
                        result.to_node       = item.frame_src;
                        result.deliver_local = (item.frame_receiver == node_id);
                        result.forward       = (item.frame_receiver != node_id);
                     end
                  end
                  default: begin
                     result.action = rcl_pkg::ACT_NONE;
                  end
               endcase
            end
         end
         rcl_pkg::KIND_SEND: begin
            if (!qstat.full && item.alloc_ok) begin
               ops_push        = 1'b1;
               result.accepted = 1'b1;
            end
         end
         default: begin
            result.action = rcl_pkg::ACT_NONE;
         end
      endcase
      result.state_now = state_in;
   end

   assign qctl.push           = advance && ops_push;
   assign qctl.pop            = advance && ops_pop;
   assign qctl.clear          = advance && ops_clear;
   assign qctl.entry.size     = rcl_pkg::HEADER_BYTES + item.req_length;
   assign qctl.entry.receiver = item.req_receiver;
   assign qctl.entry.handle   = item.req_handle;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rcl_pkg::ST_UNSYNC;
         partner_ff <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         partner_ff <= partner_in;
      end
   end

   `RCL_ASSERT_NEXT(a_send_waits_ack, clock, reset, advance && result.action == rcl_pkg::ACT_SEND_PACKET, state_ff == rcl_pkg::ST_WAIT_ACK)
   `RCL_ASSERT_NEXT(a_rts_waits_cts, clock, reset, advance && result.action == rcl_pkg::ACT_RTS, state_ff == rcl_pkg::ST_WAIT_CTS && partner_ff == $past(qstat.head.receiver))

endmodule

FILE: verif/testbench.sv
module testbench;

   localparam int DEPTH       = 8;
   localparam int PHASE_ITEMS = 500;
   localparam int STALL_LIMIT = 5000;

   class link_checker;
      logic [3:0]                  node_id;
      logic                        is_master;
      rcl_pkg::link_state_type     link_state;
      logic [3:0]                  partner;
      rcl_pkg::qentry_type         entries [DEPTH];
      int                          rd_ptr;
      int                          wr_ptr;
      int                          count;
      rcl_pkg::result_type         expected_rsp [$];
      int                          mismatches;
      int                          items;
      int                          checked;
      int                          action_hits [5];
      int                          released;
      int                          queued;
      int                          refused;
      int                          delivered;
      int                          forwarded;
      int                          resyncs;

      function void clear_queue();
         foreach (entries[i]) entries[i] = '0;
         rd_ptr = 0;
         wr_ptr = 0;
         count  = 0;
      endfunction

      function void reset_state();
         node_id    = '0;
         is_master  = 1'b0;
         link_state = rcl_pkg::ST_UNSYNC;
         partner    = '0;
         clear_queue();
      endfunction

      function void set_reg(logic idx, logic [3:0] val);
         if (idx == rcl_pkg::CSR_NODE_ID) node_id = val;
         else is_master = val[0];
      endfunction

      function void predict_item(rcl_pkg::item_type it);
         rcl_pkg::result_type r;
         rcl_pkg::qentry_type head;
         r    = '0;
         head = entries[rd_ptr];
         case (it.kind)
            rcl_pkg::KIND_START: begin
               link_state = is_master ? rcl_pkg::ST_IDLE : rcl_pkg::ST_UNSYNC;
               clear_queue();
            end
            rcl_pkg::KIND_TICK: begin
               if (link_state != rcl_pkg::ST_UNSYNC) begin
                  link_state = rcl_pkg::ST_WAIT_PACKET;
                  if (count > 0 && it.clear_first) begin
                     partner = head.receiver;
                     if (it.clear_second) begin
                        r.action   = rcl_pkg::ACT_RTS;
                        r.to_node  = partner;
                        r.rts_slot = it.slot_pick;
                        link_state = rcl_pkg::ST_WAIT_CTS;
                     end
                  end
               end
            end
            rcl_pkg::KIND_FRAME: begin
               if (it.frame_dest == node_id || it.frame_dest == rcl_pkg::BROADCAST_NODE) begin
                  case (it.frame_type)
                     rcl_pkg::FRAME_RTS: begin
                        if (link_state == rcl_pkg::ST_UNSYNC) r.timer_resync = 1'b1;
                        if (link_state == rcl_pkg::ST_WAIT_PACKET ||
                            link_state == rcl_pkg::ST_UNSYNC) begin
                           r.action   = rcl_pkg::ACT_CTS;
                           r.to_node  = it.frame_src;
                           partner    = it.frame_src;
                           link_state = rcl_pkg::ST_WAIT_DATA;
                        end
                     end
                     rcl_pkg::FRAME_CTS: begin
                        if (link_state == rcl_pkg::ST_WAIT_CTS && partner == it.frame_src
                            && count > 0) begin
                           r.action        = rcl_pkg::ACT_SEND_PACKET;
                           r.to_node       = partner;
                           r.packet_handle = head.handle;
                           r.packet_size   = head.size;
                           link_state      = rcl_pkg::ST_WAIT_ACK;
                        end else begin
                           link_state = rcl_pkg::ST_IDLE;
                        end
                     end
                     rcl_pkg::FRAME_ACK: begin
                        if (link_state == rcl_pkg::ST_WAIT_ACK && partner == it.frame_src
                            && count > 0) begin
                           r.packet_handle = head.handle;
                           r.head_done     = 1'b1;
                           rd_ptr          = (rd_ptr + 1) % DEPTH;
                           count--;
                        end
                        link_state = rcl_pkg::ST_IDLE;
                     end
                     rcl_pkg::FRAME_DATA: begin
                        if (link_state == rcl_pkg::ST_WAIT_DATA && partner == it.frame_src) begin
                           r.action  = rcl_pkg::ACT_ACK;
                           r.to_node = it.frame_src;
                           if (it.frame_receiver == node_id) r.deliver_local = 1'b1;
                           else r.forward = 1'b1;
                        end
                        link_state = rcl_pkg::ST_IDLE;
                     end
                     default: ;
                  endcase
               end
            end
            default: begin
               if (count < DEPTH && it.alloc_ok) begin
                  entries[wr_ptr].size     = rcl_pkg::HEADER_BYTES + it.req_length;
                  entries[wr_ptr].receiver = it.req_receiver;
                  entries[wr_ptr].handle   = it.req_handle;
                  wr_ptr     = (wr_ptr + 1) % DEPTH;
                  count++;
                  r.accepted = 1'b1;
               end
            end
         endcase
         r.state_now = link_state;
         items++;
         action_hits[r.action]++;
         if (r.head_done) released++;
         if (r.deliver_local) delivered++;
         if (r.forward) forwarded++;
         if (r.timer_resync) resyncs++;
         if (it.kind == rcl_pkg::KIND_SEND) begin
            if (r.accepted) queued++;
            else refused++;
         end
         expected_rsp.push_back(r);
      endfunction

      function string fmt_rsp(rcl_pkg::result_type r);
         return $sformatf({"act=%0d to=%0d slot=%0d handle=%0d size=%0d acc=%0b done=%0b",
                           " local=%0b fwd=%0b resync=%0b state=%0d"},
                          r.action, r.to_node, r.rts_slot, r.packet_handle, r.packet_size,
                          r.accepted, r.head_done, r.deliver_local, r.forward,
                          r.timer_resync, r.state_now);
      endfunction

      function void check_response(rcl_pkg::result_type got);
         rcl_pkg::result_type exp;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: %s", fmt_rsp(got));
            return;
         end
         exp = expected_rsp.pop_front();
         checked++;
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch", checked);
               $display("  expected %s", fmt_rsp(exp));
               $display("  actual   %s", fmt_rsp(got));
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind           = '0;
   logic [1:0] req_slot_pick      = '0;
   logic       req_clear_first    = 1'b0;
   logic       req_clear_second   = 1'b0;
   logic [3:0] req_frame_dest     = '0;
   logic [3:0] req_frame_src      = '0;
   logic [3:0] req_frame_type     = '0;
   logic [3:0] req_frame_receiver = '0;
   logic [3:0] req_req_receiver   = '0;
   logic [3:0] req_req_handle     = '0;
   logic [7:0] req_req_length     = '0;
   logic       req_alloc_ok       = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_action;
   logic [3:0] rsp_to_node;
   logic [1:0] rsp_rts_slot;
   logic [3:0] rsp_packet_handle;
   logic [7:0] rsp_packet_size;
   logic       rsp_accepted;
   logic       rsp_head_done;
   logic       rsp_deliver_local;
   logic       rsp_forward;
   logic       rsp_timer_resync;
   logic [2:0] rsp_state_now;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [3:0] csr_data  = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;

   link_checker sb;

   rts_cts_link_controller #(.QUEUE_DEPTH(DEPTH)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : monitor
      rcl_pkg::result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.action        = rsp_action;
            got.to_node       = rsp_to_node;
            got.rts_slot      = rsp_rts_slot;
            got.packet_handle = rsp_packet_handle;
            got.packet_size   = rsp_packet_size;
            got.accepted      = rsp_accepted;
            got.head_done     = rsp_head_done;
            got.deliver_local = rsp_deliver_local;
            got.forward       = rsp_forward;
            got.timer_resync  = rsp_timer_resync;
            got.state_now     = rsp_state_now;
            sb.check_response(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic rcl_pkg::item_type random_fields();
      rcl_pkg::item_type it;
      it.kind           = rcl_pkg::kind_type'(2'($urandom_range(3)));
      it.slot_pick      = 2'($urandom_range(3));
      it.clear_first    = 1'($urandom_range(1));
      it.clear_second   = 1'($urandom_range(1));
      it.frame_dest     = 4'($urandom_range(15));
      it.frame_src      = 4'($urandom_range(15));
      it.frame_type     = 4'($urandom_range(15));
      it.frame_receiver = 4'($urandom_range(15));
      it.req_receiver   = 4'($urandom_range(15));
      it.req_handle     = 4'($urandom_range(15));
      it.req_length     = 8'($urandom_range(255));
      it.alloc_ok       = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic rcl_pkg::item_type start_item();
      rcl_pkg::item_type it;
      it      = random_fields();
      it.kind = rcl_pkg::KIND_START;
      return it;
   endfunction

   function automatic rcl_pkg::item_type tick_item(logic [1:0] slot, logic c1, logic c2);
      rcl_pkg::item_type it;
      it              = random_fields();
      it.kind         = rcl_pkg::KIND_TICK;
      it.slot_pick    = slot;
      it.clear_first  = c1;
      it.clear_second = c2;
      return it;
   endfunction

   function automatic rcl_pkg::item_type frame_item(logic [3:0] dest, logic [3:0] src,
                                                    logic [3:0] ftype, logic [3:0] recv);
      rcl_pkg::item_type it;
      it                = random_fields();
      it.kind           = rcl_pkg::KIND_FRAME;
      it.frame_dest     = dest;
      it.frame_src      = src;
      it.frame_type     = ftype;
      it.frame_receiver = recv;
      return it;
   endfunction

   function automatic rcl_pkg::item_type send_item(logic [3:0] recv, logic [3:0] handle,
                                                   logic [7:0] len, logic ok);
      rcl_pkg::item_type it;
      it              = random_fields();
      it.kind         = rcl_pkg::KIND_SEND;
      it.req_receiver = recv;
      it.req_handle   = handle;
      it.req_length   = len;
      it.alloc_ok     = ok;
      return it;
   endfunction

   // mostly well-formed exchanges for the current link state, the rest noise
   function automatic rcl_pkg::item_type next_link_item();
      rcl_pkg::item_type it;
      int                r;
      logic [3:0]        dest;
      it = random_fields();
      if (it.kind == rcl_pkg::KIND_START && $urandom_range(7) != 0)
         it.kind = rcl_pkg::KIND_FRAME;
      r    = $urandom_range(99);
      dest = ($urandom_range(3) == 0) ? rcl_pkg::BROADCAST_NODE : sb.node_id;
      if (r < 25) return it;
      case (sb.link_state)
         rcl_pkg::ST_UNSYNC: begin
            if (r < 30) it = start_item();
            else it = frame_item(dest, 4'($urandom_range(15)), rcl_pkg::FRAME_RTS,
                                 4'($urandom_range(15)));
         end
         rcl_pkg::ST_WAIT_CTS: begin
            if (r < 85)
               it = frame_item(dest, sb.partner, rcl_pkg::FRAME_CTS, 4'($urandom_range(15)));
         end
         rcl_pkg::ST_WAIT_ACK: begin
            if (r < 85)
               it = frame_item(dest, sb.partner, rcl_pkg::FRAME_ACK, 4'($urandom_range(15)));
         end
         rcl_pkg::ST_WAIT_DATA: begin
            if (r < 85)
               it = frame_item(dest, sb.partner, rcl_pkg::FRAME_DATA,
                               (r < 55) ? sb.node_id : 4'($urandom_range(15)));
         end
         default: begin
            if (r < 55)
               it = send_item(4'($urandom_range(15)), 4'($urandom_range(15)),
                              8'($urandom_range(251)), $urandom_range(9) != 0);
            else if (r < 85)
               it = tick_item(2'($urandom_range(3)), $urandom_range(4) != 0,
                              $urandom_range(4) != 0);
            else
               it = frame_item(dest, 4'($urandom_range(15)), rcl_pkg::FRAME_RTS,
                               4'($urandom_range(15)));
         end
      endcase
      return it;
   endfunction

   task automatic drive_item(input rcl_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= it.kind;
      req_slot_pick      <= it.slot_pick;
      req_clear_first    <= it.clear_first;
      req_clear_second   <= it.clear_second;
      req_frame_dest     <= it.frame_dest;
      req_frame_src      <= it.frame_src;
      req_frame_type     <= it.frame_type;
      req_frame_receiver <= it.frame_receiver;
      req_req_receiver   <= it.req_receiver;
      req_req_handle     <= it.req_handle;
      req_req_length     <= it.req_length;
      req_alloc_ok       <= it.alloc_ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_item(it);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   initial begin : stimulus
      rcl_pkg::item_type it;
      logic [3:0]        node;
      logic              master;
      int                done;
      sb = new();
      sb.reset_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin node = 4'd0;  master = 1'b1; send_idle_pct = 0;  stall_pct = 0;  end
            1: begin node = 4'd14; master = 1'b0; send_idle_pct = 52; stall_pct = 0;  end
            2: begin
               node = 4'($urandom_range(1, 13)); master = 1'b1;
               send_idle_pct = 0; stall_pct = 52;
            end
            default: begin
               node = 4'($urandom_range(14)); master = 1'b0;
               send_idle_pct = 6; stall_pct = 6;
            end
         endcase
         req_valid <= 1'b0;
         while (sb.expected_rsp.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         write_reg(rcl_pkg::CSR_NODE_ID, node);
         write_reg(rcl_pkg::CSR_IS_MASTER, {3'b000, master});
         csr_valid <= 1'b0;
         done = 0;

         if (ph == 0) begin
            // RTS while unsynchronised and the data exchange it opens, then directed ticks, sends and frames
            drive_item(frame_item(rcl_pkg::BROADCAST_NODE, 4'd3, rcl_pkg::FRAME_RTS, 4'd5));
            drive_item(frame_item(4'd0, 4'd3, rcl_pkg::FRAME_DATA, 4'd0));
            drive_item(start_item());
            drive_item(tick_item(2'd0, 1'b1, 1'b1));
            drive_item(send_item(4'd15, 4'd15, 8'd251, 1'b0));
            drive_item(send_item(4'd15, 4'd15, 8'd251, 1'b1));
            drive_item(send_item(4'd0, 4'd0, 8'd255, 1'b1));
            drive_item(tick_item(2'd1, 1'b1, 1'b0));
            drive_item(tick_item(2'd2, 1'b0, 1'b1));
            drive_item(tick_item(2'd3, 1'b1, 1'b1));
            drive_item(frame_item(4'd0, 4'd4, rcl_pkg::FRAME_CTS, 4'd0));
            drive_item(tick_item(2'd0, 1'b1, 1'b1));
            drive_item(frame_item(rcl_pkg::BROADCAST_NODE, 4'd15, rcl_pkg::FRAME_CTS, 4'd0));
            drive_item(frame_item(4'd0, 4'd2, rcl_pkg::FRAME_ACK, 4'd0));
            drive_item(tick_item(2'd1, 1'b1, 1'b1));
            drive_item(frame_item(4'd0, 4'd15, rcl_pkg::FRAME_CTS, 4'd0));
            drive_item(frame_item(4'd0, 4'd15, rcl_pkg::FRAME_ACK, 4'd0));
            drive_item(frame_item(4'd5, 4'd15, rcl_pkg::FRAME_CTS, 4'd0));
            drive_item(frame_item(4'd0, 4'd1, 4'd9, 4'd0));
            drive_item(tick_item(2'd0, 1'b0, 1'b0));
            drive_item(frame_item(4'd0, 4'd9, rcl_pkg::FRAME_RTS, 4'd0));
            drive_item(frame_item(4'd0, 4'd9, rcl_pkg::FRAME_DATA, 4'd6));
            drive_item(frame_item(4'd0, 4'd2, rcl_pkg::FRAME_ACK, 4'd0));
            drive_item(frame_item(4'd0, 4'd8, rcl_pkg::FRAME_DATA, 4'd0));
            done = 24;
         end

         while (done < PHASE_ITEMS) begin
            it = next_link_item();
            // frames that the filter drops do not count
            if (!(it.kind == rcl_pkg::KIND_FRAME && ((it.frame_dest != sb.node_id
                  && it.frame_dest != rcl_pkg::BROADCAST_NODE)
                  || it.frame_type > rcl_pkg::FRAME_DATA)))
               done++;
            drive_item(it);
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d items, %0d responses checked; rts %0d, cts %0d, packets %0d, acks %0d",
               sb.items, sb.checked, sb.action_hits[rcl_pkg::ACT_RTS],
               sb.action_hits[rcl_pkg::ACT_CTS], sb.action_hits[rcl_pkg::ACT_SEND_PACKET],
               sb.action_hits[rcl_pkg::ACT_ACK]);
      $display("queued %0d, refused %0d, released %0d, local %0d, forwarded %0d, resync %0d",
               sb.queued, sb.refused, sb.released, sb.delivered, sb.forwarded, sb.resyncs);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses outstanding",
                  sb.mismatches, sb.expected_rsp.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
